### rtl/core/lwpg_pkg.sv
package lwpg_pkg;

   // core population and derived widths
   localparam int NUM_CORES = 16;
   localparam int IDX_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int TOP_W     = $clog2(NUM_CORES + 1);

   // field widths
   localparam int CORE_W  = 4;
   localparam int BUSY_W  = 32;
   localparam int TICK_W  = 48;
   localparam int CNT_W   = 16;
   localparam int GAIN_W  = 8;
   localparam int PST_W   = 3;
   localparam int OTOP_W  = 5;
   localparam int NEED_W  = CNT_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = TICK_W;

   // shallowest and deepest P-state codes
   localparam logic [PST_W-1:0] PSTATE_TOP  = '0;
   localparam logic [PST_W:0]   PSTATE_LAST = 4'd7;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_UP_TICKS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DOWN_TICKS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_WINDOW_BASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUSY_CORE_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEEPEST_STATE   = 3'd5;

   // register reset values
   localparam logic [CNT_W-1:0]  RST_LOW_WINDOW_BASE = 16'd4;
   localparam logic [GAIN_W-1:0] RST_BUSY_CORE_GAIN  = 8'd1;
   localparam logic [PST_W-1:0]  RST_DEEPEST_STATE   = 3'd7;

   // job kinds set by the front end
   localparam logic [1:0] JOB_REPORT = 2'd0;
   localparam logic [1:0] JOB_RESET  = 2'd1;
   localparam logic [1:0] JOB_SKIP   = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CORE_W-1:0] core;
      logic [BUSY_W-1:0] busy;
      logic [BUSY_W-1:0] idle;
   } job_type;

endpackage

### rtl/core/lwpg_if.sv
interface lwpg_req_if import lwpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [CORE_W-1:0] core_index;
   logic [BUSY_W-1:0] busy_ticks;
   logic [BUSY_W-1:0] idle_ticks;

   modport source (output valid, output action, output core_index, output busy_ticks,
                   output idle_ticks, input ready);
   modport sink   (input valid, input action, input core_index, input busy_ticks,
                   input idle_ticks, output ready);
endinterface

interface lwpg_rsp_if import lwpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CORE_W-1:0] core_out;
   logic              state_written;
   logic [PST_W-1:0]  new_state;
   logic              window_closed;
   logic [OTOP_W-1:0] cores_at_top;
   logic              last_result;

   modport source (output valid, output core_out, output state_written, output new_state,
                   output window_closed, output cores_at_top, output last_result,
                   input ready);
   modport sink   (input valid, input core_out, input state_written, input new_state,
                   input window_closed, input cores_at_top, input last_result,
                   output ready);
endinterface

### rtl/core/load_window_pstate_governor.sv
// Channel   Dir  Handshake      Beat contents
// req_ch    in   valid/ready    action, core_index, busy_ticks, idle_ticks
// rsp_ch    out  valid/ready    core_out, state_written, new_state, window_closed,
//                               cores_at_top, last_result
// csr_*     in   csr_wr_en      csr_index, csr_wr_data (no read-back)
//
// An idle-exit report steps the back-end sequencer through pop, sum, window check, load
// judge and emit, and the emit step registers its result beat onto rsp_ch. The sequencer
// reads and writes one core's window state at a time.
// A reset-all action emits one beat per core. The request side accepts into the two-entry
// queue until both entries are taken; a result beat held by a low rsp_ch.ready stalls the
// back end. Reset is synchronous and restores all cores to P0 and the registers to their
// defaults.
module load_window_pstate_governor import lwpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lwpg_req_if.sink              req_ch,
   lwpg_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic    job_valid;
   logic    job_pop;
   job_type job;

   lwpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job)
   );

   lwpg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .job_valid   (job_valid),
      .job_pop     (job_pop),
      .job         (job),
      .rsp_ch      (rsp_ch)
   );

   // the back end only pulls a job when one is queued
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("job popped from empty queue");

   // only the reset-all sequence gives beats that are not last
   a_multi_is_reset: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last_result) |->
         (rsp_ch.state_written && rsp_ch.new_state == PSTATE_TOP && !rsp_ch.window_closed))
      else $error("non-final beat outside reset sequence");

   // count of cores at P0 never passes the core count
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (32'(rsp_ch.cores_at_top) <= NUM_CORES))
      else $error("cores_at_top out of range");

   // a state write to a deeper state leaves at least one core below P0
   a_deeper_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.state_written && rsp_ch.new_state != PSTATE_TOP) |->
         (32'(rsp_ch.cores_at_top) < NUM_CORES))
      else $error("deeper write with all cores at P0");

endmodule

### rtl/core/lwpg_front.sv
module lwpg_front import lwpg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lwpg_req_if.sink   req_ch,
   output logic       job_valid,
   input  logic       job_pop,
   output job_type    job
);

   job_type    queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   job_type    entry;
   logic       push;

   assign req_ch.ready = (count_ff < 2'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign job_valid    = (count_ff != 2'd0);
   assign job          = queue_ff[rd_ptr_ff];

   // classify the beat
   always_comb begin
      entry.core = req_ch.core_index;
      entry.busy = req_ch.busy_ticks;
      entry.idle = req_ch.idle_ticks;
      if (req_ch.action) begin
         entry.kind = JOB_RESET;
      end else if (32'(req_ch.core_index) >= NUM_CORES) begin
         entry.kind = JOB_SKIP;
      end else begin
         entry.kind = JOB_REPORT;
      end
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### rtl/core/lwpg_back.sv
module lwpg_back import lwpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  job_valid,
   output logic                  job_pop,
   input  job_type               job,
   lwpg_rsp_if.source            rsp_ch
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_JUDGE = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_RESET = 3'd5;

   logic [2:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   logic [TICK_W-1:0] sum_total_ff, sum_total_in;
   logic [TICK_W-1:0] sum_idle_ff, sum_idle_in;
   logic [TICK_W-1:0] run_ff, run_in;
   logic              closed_ff, closed_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              wr_ff, wr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [TICK_W-1:0] window_ticks_ff, window_ticks_in;
   logic [TICK_W-1:0] step_up_ff, step_up_in;
   logic [TICK_W-1:0] step_down_ff, step_down_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [PST_W-1:0]  deepest_ff, deepest_in;
   logic [TOP_W-1:0]  top_ff, top_in;

   logic [PST_W-1:0]  pstate_ff [NUM_CORES];
   logic [PST_W-1:0]  pstate_in [NUM_CORES];
   logic [CNT_W-1:0]  low_cnt_ff [NUM_CORES];
   logic [CNT_W-1:0]  low_cnt_in [NUM_CORES];
   logic [TICK_W-1:0] total_ff [NUM_CORES];
   logic [TICK_W-1:0] total_in [NUM_CORES];
   logic [TICK_W-1:0] idle_ff [NUM_CORES];
   logic [TICK_W-1:0] idle_in [NUM_CORES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CORE_W-1:0] rsp_core_ff, rsp_core_in;
   logic              rsp_written_ff, rsp_written_in;
   logic [PST_W-1:0]  rsp_state_ff, rsp_state_in;
   logic              rsp_closed_ff, rsp_closed_in;
   logic [OTOP_W-1:0] rsp_top_ff, rsp_top_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]  ci;
   logic              out_free;
   logic [TICK_W:0]   add_total;
   logic [TICK_W:0]   add_idle;
   logic [PST_W-1:0]  cur;
   logic [CNT_W-1:0]  cnt_inc;
   logic              want_valid;
   logic [PST_W:0]    want;
   logic [PST_W-1:0]  want_clamped;

   assign ci       = job_ff.core[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.core_out      = rsp_core_ff;
   assign rsp_ch.state_written = rsp_written_ff;
   assign rsp_ch.new_state     = rsp_state_ff;
   assign rsp_ch.window_closed = rsp_closed_ff;
   assign rsp_ch.cores_at_top  = rsp_top_ff;
   assign rsp_ch.last_result   = rsp_last_ff;

   always_comb begin
      add_total = {1'b0, total_ff[ci]} + (TICK_W+1)'(job_ff.busy)
                  + (TICK_W+1)'(job_ff.idle);
      add_idle  = {1'b0, idle_ff[ci]} + (TICK_W+1)'(job_ff.idle);
      cur       = pstate_ff[ci];
      cnt_inc   = (low_cnt_ff[ci] == CNT_MAX) ? CNT_MAX : low_cnt_ff[ci] + 1'b1;
   end

   always_comb begin
      state_in        = state_ff;
      job_in          = job_ff;
      sum_total_in    = sum_total_ff;
      sum_idle_in     = sum_idle_ff;
      run_in          = run_ff;
      closed_in       = closed_ff;
      need_in         = need_ff;
      wr_in           = wr_ff;
      idx_in          = idx_ff;
      window_ticks_in = window_ticks_ff;
      step_up_in      = step_up_ff;
      step_down_in    = step_down_ff;
      base_in         = base_ff;
      gain_in         = gain_ff;
      deepest_in      = deepest_ff;
      top_in          = top_ff;
      pstate_in       = pstate_ff;
      low_cnt_in      = low_cnt_ff;
      total_in        = total_ff;
      idle_in         = idle_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_core_in     = rsp_core_ff;
      rsp_written_in  = rsp_written_ff;
      rsp_state_in    = rsp_state_ff;
      rsp_closed_in   = rsp_closed_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_last_in     = rsp_last_ff;
      want_valid      = 1'b0;
      want            = '0;
      want_clamped    = '0;

      if (csr_wr_en) begin
         case (csr_index)
            REG_WINDOW_TICKS:    window_ticks_in = csr_wr_data;
            REG_STEP_UP_TICKS:   step_up_in      = csr_wr_data;
            REG_STEP_DOWN_TICKS: step_down_in    = csr_wr_data;
            REG_LOW_WINDOW_BASE: base_in         = csr_wr_data[CNT_W-1:0];
            REG_BUSY_CORE_GAIN:  gain_in         = csr_wr_data[GAIN_W-1:0];
            REG_DEEPEST_STATE:   deepest_in      = csr_wr_data[PST_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in = job;
               case (job.kind)
                  JOB_RESET: begin
                     if (deepest_ff == '0) begin
                        deepest_in = PST_W'(1);
                     end
                     top_in   = '0;
                     idx_in   = '0;
                     state_in = ST_RESET;
                  end
                  JOB_REPORT: state_in = ST_SUM;
                  default: begin
                     wr_in     = 1'b0;
                     closed_in = 1'b0;
                     state_in  = ST_EMIT;
                  end
               endcase
            end
         end
         ST_SUM: begin
            sum_total_in = add_total[TICK_W] ? '1 : add_total[TICK_W-1:0];
            sum_idle_in  = add_idle[TICK_W] ? '1 : add_idle[TICK_W-1:0];
            state_in     = ST_RUN;
         end
         ST_RUN: begin
            closed_in = sum_total_ff > window_ticks_ff;
            run_in    = (sum_total_ff > sum_idle_ff) ? sum_total_ff - sum_idle_ff : '0;
            need_in   = NEED_W'(base_ff) + NEED_W'(top_ff * gain_ff);
            if (sum_total_ff > window_ticks_ff) begin
               total_in[ci] = '0;
               idle_in[ci]  = '0;
            end else begin
               total_in[ci] = sum_total_ff;
               idle_in[ci]  = sum_idle_ff;
            end
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            wr_in = 1'b0;
            if (closed_ff) begin
               if (run_ff > step_up_ff) begin
                  want_valid     = 1'b1;
                  want           = '0;
                  low_cnt_in[ci] = '0;
               end else if (run_ff < step_down_ff) begin
                  if (NEED_W'(cnt_inc) > need_ff) begin
                     low_cnt_in[ci] = '0;
                     want_valid     = 1'b1;
                     want           = {1'b0, cur} + 1'b1;
                  end else begin
                     low_cnt_in[ci] = cnt_inc;
                  end
               end
            end
            // clamp to the deepest legal state, then to the configured limit
            want_clamped = (want > PSTATE_LAST) ? PSTATE_LAST[PST_W-1:0] : want[PST_W-1:0];
            if (want_clamped > deepest_ff) begin
               want_clamped = deepest_ff;
            end
            if (want_valid && (deepest_ff != '0) && (want_clamped != cur)) begin
               wr_in         = 1'b1;
               pstate_in[ci] = want_clamped;
               if (want_clamped == PSTATE_TOP) begin
                  if (32'(top_ff) < NUM_CORES) begin
                     top_in = top_ff + 1'b1;
                  end
               end else if (cur == PSTATE_TOP) begin
                  if (top_ff != '0) begin
                     top_in = top_ff - 1'b1;
                  end
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_core_in    = job_ff.core;
               rsp_written_in = wr_ff;
               rsp_state_in   = (job_ff.kind == JOB_REPORT) ? pstate_ff[ci] : PSTATE_TOP;
               rsp_closed_in  = closed_ff;
               rsp_top_in     = OTOP_W'(top_ff);
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_RESET: begin
            // one core per beat, count climbs with it
            if (out_free) begin
               pstate_in[idx_ff] = PSTATE_TOP;
               top_in            = TOP_W'(idx_ff) + 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_core_in       = CORE_W'(idx_ff);
               rsp_written_in    = 1'b1;
               rsp_state_in      = PSTATE_TOP;
               rsp_closed_in     = 1'b0;
               rsp_top_in        = OTOP_W'(TOP_W'(idx_ff) + 1'b1);
               rsp_last_in       = (32'(idx_ff) == NUM_CORES - 1);
               if (32'(idx_ff) == NUM_CORES - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         window_ticks_ff <= '0;
         step_up_ff      <= '0;
         step_down_ff    <= '0;
         base_ff         <= RST_LOW_WINDOW_BASE;
         gain_ff         <= RST_BUSY_CORE_GAIN;
         deepest_ff      <= RST_DEEPEST_STATE;
         top_ff          <= TOP_W'(NUM_CORES);
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < NUM_CORES; i++) begin
            pstate_ff[i]  <= PSTATE_TOP;
            low_cnt_ff[i] <= '0;
            total_ff[i]   <= '0;
            idle_ff[i]    <= '0;
         end
      end else begin
         state_ff        <= state_in;
         window_ticks_ff <= window_ticks_in;
         step_up_ff      <= step_up_in;
         step_down_ff    <= step_down_in;
         base_ff         <= base_in;
         gain_ff         <= gain_in;
         deepest_ff      <= deepest_in;
         top_ff          <= top_in;
         rsp_valid_ff    <= rsp_valid_in;
         pstate_ff       <= pstate_in;
         low_cnt_ff      <= low_cnt_in;
         total_ff        <= total_in;
         idle_ff         <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      sum_total_ff   <= sum_total_in;
      sum_idle_ff    <= sum_idle_in;
      run_ff         <= run_in;
      closed_ff      <= closed_in;
      need_ff        <= need_in;
      wr_ff          <= wr_in;
      idx_ff         <= idx_in;
      rsp_core_ff    <= rsp_core_in;
      rsp_written_ff <= rsp_written_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_closed_ff  <= rsp_closed_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule
